// ===== src/lprr_pkg.sv =====
package lprr_pkg;

    localparam int DEPTH        = 4096;
    localparam int ADDR_W       = 12;
    localparam int PTR_W        = 13;
    localparam int LEN_W        = 12;
    localparam int HEADER_BYTES = 4;
    localparam int MIN_LEN      = 16;

    typedef enum logic [1:0] {
        ACT_WRITE_BEGIN = 2'd0,
        ACT_WRITE_BYTE  = 2'd1,
        ACT_READ_BEGIN  = 2'd2,
        ACT_READ_BYTE   = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_ERROR     = 3'd3,
        ST_NO_ENOUGH = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_WHDR,
        SQ_RHDR,
        SQ_RCHK,
        SQ_RDAT
    } seq_state_t;

    // where the header of the record being opened for read sits
    typedef enum logic [1:0] {
        HC_IN_ORDER,
        HC_AT_HEAD,
        HC_AT_ZERO
    } hdr_case_t;

    typedef struct packed {
        logic               valid;
        status_t            status;
        logic [LEN_W-1:0]   record_length;
        logic [7:0]         data_out;
        logic               last;
    } result_t;

endpackage

// ===== src/lprr_ram.sv =====
module lprr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== src/lprr_seq.sv =====
module lprr_seq (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clr,
    input  logic [lprr_pkg::PTR_W-1:0]  blen,
    input  logic                        out_busy,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  in_action,
    input  logic [lprr_pkg::LEN_W-1:0]  in_length,
    input  logic [7:0]                  in_data,
    output lprr_pkg::result_t           res,
    output logic                        ram_we,
    output logic [lprr_pkg::ADDR_W-1:0] ram_addr,
    output logic [7:0]                  ram_wdata,
    input  logic [7:0]                  ram_rdata
);

    localparam int W = lprr_pkg::PTR_W + 1;
    localparam int WL = 34;

    lprr_pkg::seq_state_t state_reg, state_next;
    lprr_pkg::hdr_case_t  hcase_reg, hcase_next;

    logic [lprr_pkg::PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [lprr_pkg::PTR_W-1:0] write_ptr_reg, write_ptr_next;
    logic [lprr_pkg::PTR_W-1:0] fill_ptr_reg, fill_ptr_next;
    logic [lprr_pkg::LEN_W-1:0] fill_left_reg, fill_left_next;
    logic                       fill_open_reg, fill_open_next;
    logic [lprr_pkg::PTR_W-1:0] drain_ptr_reg, drain_ptr_next;
    logic [lprr_pkg::LEN_W-1:0] drain_left_reg, drain_left_next;
    logic [2:0]                 cnt_reg, cnt_next;
    logic [lprr_pkg::PTR_W-1:0] hdr_addr_reg, hdr_addr_next;
    logic [lprr_pkg::LEN_W-1:0] len_reg, len_next;
    logic [31:0]                hdr_reg, hdr_next;
    logic                       last_reg, last_next;

    logic accept;
    lprr_pkg::action_t act;

    // write_begin fit check
    logic [W-1:0] head_w, tail_w, blen_w, len_w;
    logic         wb_ok;
    logic [lprr_pkg::PTR_W-1:0] wb_hpos, wb_dpos;

    // read_begin routing
    logic rb_fail, rb_empty, rb_zero;

    // header check
    logic [WL-1:0] hlen, hhead, htail, hblen;
    logic          rc_fail;
    logic [lprr_pkg::PTR_W-1:0] rc_dstart;
    logic [WL-1:0] rc_end;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == lprr_pkg::SQ_IDLE) && !out_busy;
    assign act      = lprr_pkg::action_t'(in_action);

    assign head_w = {1'b0, read_ptr_reg};
    assign tail_w = {1'b0, write_ptr_reg};
    assign blen_w = {1'b0, blen};
    assign len_w  = {2'b0, in_length};

    // placement of a new record
    always_comb begin
        wb_ok   = 1'b0;
        wb_hpos = write_ptr_reg;
        wb_dpos = write_ptr_reg + lprr_pkg::PTR_W'(lprr_pkg::HEADER_BYTES);
        if (head_w <= tail_w) begin
            if (tail_w + W'(lprr_pkg::HEADER_BYTES) + len_w <= blen_w) begin
                wb_ok = 1'b1;
            end else if (tail_w + W'(lprr_pkg::HEADER_BYTES) <= blen_w) begin
                wb_ok   = len_w < head_w;
                wb_dpos = '0;
            end else begin
                wb_ok   = len_w + W'(lprr_pkg::HEADER_BYTES) < head_w;
                wb_hpos = '0;
                wb_dpos = lprr_pkg::PTR_W'(lprr_pkg::HEADER_BYTES);
            end
        end else begin
            wb_ok = tail_w + W'(lprr_pkg::HEADER_BYTES) + len_w < head_w;
        end
    end

    // read_begin decisions that need no header
    always_comb begin
        rb_fail  = 1'b0;
        rb_empty = 1'b0;
        rb_zero  = 1'b0;
        if (head_w < tail_w) begin
            rb_fail = head_w + W'(lprr_pkg::HEADER_BYTES) > tail_w;
        end else if (head_w > tail_w) begin
            if (head_w + W'(lprr_pkg::HEADER_BYTES) > blen_w) begin
                rb_zero = 1'b1;
                if (write_ptr_reg == '0) begin
                    rb_empty = 1'b1;
                end else if (tail_w < W'(lprr_pkg::HEADER_BYTES)) begin
                    rb_fail = 1'b1;
                end
            end
        end else begin
            rb_empty = 1'b1;
        end
    end

    // header check once the length is in
    assign hlen  = {2'b0, hdr_reg};
    assign hhead = WL'(read_ptr_reg);
    assign htail = WL'(write_ptr_reg);
    assign hblen = WL'(blen);

    always_comb begin
        rc_fail   = 1'b0;
        rc_dstart = read_ptr_reg + lprr_pkg::PTR_W'(lprr_pkg::HEADER_BYTES);
        case (hcase_reg)
            lprr_pkg::HC_IN_ORDER: begin
                rc_fail = hhead + WL'(lprr_pkg::HEADER_BYTES) + hlen > htail;
            end
            lprr_pkg::HC_AT_HEAD: begin
                if (hlen + hhead + WL'(lprr_pkg::HEADER_BYTES) > hblen) begin
                    rc_dstart = '0;
                    rc_fail   = (htail < WL'(lprr_pkg::HEADER_BYTES)) || (hlen > htail);
                end
            end
            default: begin
                rc_dstart = lprr_pkg::PTR_W'(lprr_pkg::HEADER_BYTES);
                rc_fail   = WL'(lprr_pkg::HEADER_BYTES) + hlen > htail;
            end
        endcase
        rc_end = WL'(rc_dstart) + hlen;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lprr_pkg::SQ_IDLE: begin
                if (accept) begin
                    case (act)
                        lprr_pkg::ACT_WRITE_BEGIN: begin
                            if (wb_ok) state_next = lprr_pkg::SQ_WHDR;
                        end
                        lprr_pkg::ACT_READ_BEGIN: begin
                            if (!rb_fail && !rb_empty) state_next = lprr_pkg::SQ_RHDR;
                        end
                        lprr_pkg::ACT_READ_BYTE: begin
                            if (drain_left_reg != '0) state_next = lprr_pkg::SQ_RDAT;
                        end
                        default: state_next = lprr_pkg::SQ_IDLE;
                    endcase
                end
            end
            lprr_pkg::SQ_WHDR: begin
                if (cnt_reg == 3'd3) state_next = lprr_pkg::SQ_IDLE;
            end
            lprr_pkg::SQ_RHDR: begin
                if (cnt_reg == 3'd4) state_next = lprr_pkg::SQ_RCHK;
            end
            lprr_pkg::SQ_RCHK: state_next = lprr_pkg::SQ_IDLE;
            lprr_pkg::SQ_RDAT: state_next = lprr_pkg::SQ_IDLE;
            default: state_next = lprr_pkg::SQ_IDLE;
        endcase
    end

    // datapath, memory port and result
    always_comb begin
        read_ptr_next   = read_ptr_reg;
        write_ptr_next  = write_ptr_reg;
        fill_ptr_next   = fill_ptr_reg;
        fill_left_next  = fill_left_reg;
        fill_open_next  = fill_open_reg;
        drain_ptr_next  = drain_ptr_reg;
        drain_left_next = drain_left_reg;
        cnt_next        = cnt_reg;
        hdr_addr_next   = hdr_addr_reg;
        len_next        = len_reg;
        hdr_next        = hdr_reg;
        hcase_next      = hcase_reg;
        last_next       = last_reg;
        ram_we          = 1'b0;
        ram_addr        = hdr_addr_reg[lprr_pkg::ADDR_W-1:0];
        ram_wdata       = '0;
        res             = '0;
        res.status      = lprr_pkg::ST_OK;

        case (state_reg)
            lprr_pkg::SQ_IDLE: begin
                cnt_next = '0;
                if (accept) begin
                    case (act)
                        lprr_pkg::ACT_WRITE_BEGIN: begin
                            fill_open_next = 1'b0;
                            fill_left_next = '0;
                            len_next       = in_length;
                            if (wb_ok) begin
                                hdr_addr_next = wb_hpos;
                                fill_ptr_next = wb_dpos;
                                if (in_length == '0) begin
                                    write_ptr_next = wb_dpos;
                                end else begin
                                    fill_left_next = in_length;
                                    fill_open_next = 1'b1;
                                end
                            end else begin
                                res.valid  = 1'b1;
                                res.status = lprr_pkg::ST_FULL;
                            end
                        end
                        lprr_pkg::ACT_WRITE_BYTE: begin
                            res.valid = 1'b1;
                            if (fill_open_reg) begin
                                ram_we         = 1'b1;
                                ram_addr       = fill_ptr_reg[lprr_pkg::ADDR_W-1:0];
                                ram_wdata      = in_data;
                                fill_ptr_next  = fill_ptr_reg + 1'b1;
                                fill_left_next = fill_left_reg - 1'b1;
                                if (fill_left_reg == lprr_pkg::LEN_W'(1)) begin
                                    write_ptr_next = fill_ptr_reg + 1'b1;
                                    fill_open_next = 1'b0;
                                end
                            end else begin
                                res.status = lprr_pkg::ST_ERROR;
                            end
                        end
                        lprr_pkg::ACT_READ_BEGIN: begin
                            drain_left_next = '0;
                            len_next        = in_length;
                            if (rb_zero) read_ptr_next = '0;
                            if (rb_fail) begin
                                read_ptr_next  = '0;
                                write_ptr_next = '0;
                                fill_ptr_next  = '0;
                                fill_left_next = '0;
                                fill_open_next = 1'b0;
                                drain_ptr_next = '0;
                                res.valid      = 1'b1;
                                res.status     = lprr_pkg::ST_ERROR;
                            end else if (rb_empty) begin
                                res.valid  = 1'b1;
                                res.status = lprr_pkg::ST_EMPTY;
                            end else if (rb_zero) begin
                                hdr_addr_next = '0;
                                hcase_next    = lprr_pkg::HC_AT_ZERO;
                            end else begin
                                hdr_addr_next = read_ptr_reg;
                                hcase_next    = (read_ptr_reg < write_ptr_reg) ?
                                                lprr_pkg::HC_IN_ORDER : lprr_pkg::HC_AT_HEAD;
                            end
                        end
                        default: begin
                            if (drain_left_reg != '0) begin
                                ram_addr        = drain_ptr_reg[lprr_pkg::ADDR_W-1:0];
                                drain_ptr_next  = drain_ptr_reg + 1'b1;
                                drain_left_next = drain_left_reg - 1'b1;
                                last_next       = drain_left_reg == lprr_pkg::LEN_W'(1);
                                if (drain_left_reg == lprr_pkg::LEN_W'(1)) begin
                                    read_ptr_next = drain_ptr_reg + 1'b1;
                                end
                            end else begin
                                res.valid  = 1'b1;
                                res.status = lprr_pkg::ST_EMPTY;
                            end
                        end
                    endcase
                end
            end
            // header bytes, little endian, upper two always zero
            lprr_pkg::SQ_WHDR: begin
                ram_we   = 1'b1;
                ram_addr = hdr_addr_reg[lprr_pkg::ADDR_W-1:0] + lprr_pkg::ADDR_W'(cnt_reg);
                case (cnt_reg)
                    3'd0:    ram_wdata = len_reg[7:0];
                    3'd1:    ram_wdata = {4'b0, len_reg[11:8]};
                    default: ram_wdata = '0;
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd3) begin
                    res.valid = 1'b1;
                end
            end
            // issue four reads, shift in each byte in the cycle after its read
            lprr_pkg::SQ_RHDR: begin
                ram_addr = hdr_addr_reg[lprr_pkg::ADDR_W-1:0] + lprr_pkg::ADDR_W'(cnt_reg);
                if (cnt_reg != '0) begin
                    hdr_next = {ram_rdata, hdr_reg[31:8]};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            lprr_pkg::SQ_RCHK: begin
                res.valid = 1'b1;
                if (rc_fail) begin
                    read_ptr_next  = '0;
                    write_ptr_next = '0;
                    fill_ptr_next  = '0;
                    fill_left_next = '0;
                    fill_open_next = 1'b0;
                    drain_ptr_next = '0;
                    res.status     = lprr_pkg::ST_ERROR;
                end else begin
                    res.record_length = hdr_reg[lprr_pkg::LEN_W-1:0];
                    drain_ptr_next    = rc_dstart;
                    if (hlen > WL'(len_reg)) begin
                        read_ptr_next = rc_end[lprr_pkg::PTR_W-1:0];
                        res.status    = lprr_pkg::ST_NO_ENOUGH;
                    end else if (hdr_reg == '0) begin
                        read_ptr_next = rc_dstart;
                    end else begin
                        drain_left_next = hdr_reg[lprr_pkg::LEN_W-1:0];
                    end
                end
            end
            lprr_pkg::SQ_RDAT: begin
                res.valid    = 1'b1;
                res.data_out = ram_rdata;
                res.last     = last_reg;
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn || clr) begin
            state_reg      <= lprr_pkg::SQ_IDLE;
            read_ptr_reg   <= '0;
            write_ptr_reg  <= '0;
            fill_ptr_reg   <= '0;
            fill_left_reg  <= '0;
            fill_open_reg  <= 1'b0;
            drain_ptr_reg  <= '0;
            drain_left_reg <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            read_ptr_reg   <= read_ptr_next;
            write_ptr_reg  <= write_ptr_next;
            fill_ptr_reg   <= fill_ptr_next;
            fill_left_reg  <= fill_left_next;
            fill_open_reg  <= fill_open_next;
            drain_ptr_reg  <= drain_ptr_next;
            drain_left_reg <= drain_left_next;
            cnt_reg        <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        hdr_addr_reg <= hdr_addr_next;
        len_reg      <= len_next;
        hdr_reg      <= hdr_next;
        hcase_reg    <= hcase_next;
        last_reg     <= last_next;
    end

endmodule

// ===== src/length_prefixed_record_ring.sv =====
// Length-prefixed record ring: a byte ring of buffer_len bytes holding records,
// each behind a 4-byte little-endian length header.
// Input transactions on s_*: s_tuser picks write_begin, write_byte, read_begin
// or read_byte; s_tdata carries the length (or read capacity) and the byte.
// Every input transaction gives exactly one result transaction on m_*: status in
// m_tuser, record length and data byte in m_tdata, final record byte on m_tlast.
// One transaction is in flight at a time; the single-port byte memory sets the
// pace. write_byte and checks that fail on acceptance register their result
// directly; read_byte first reads its byte, write_begin first makes four header
// byte writes, and read_begin four header byte reads, then the header check.
// The next input is taken once the result register has been emptied by the m_*
// handshake.
// When the receiver stalls the result is held in the output register and
// s_tready stays low. Reset (aresetn low, synchronous) clears all pointers and
// sets buffer_len to 4096; the ring contents are not cleared and need no pass.
// A write on cfg_we clamps the value to 16..4096 and clears all pointers.
module length_prefixed_record_ring (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // length [11:0], data_in [19:12], zero [23:20]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // record_length [11:0], data_out [19:12], zero [23:20]
    output logic [2:0]  m_tuser,   // status [2:0]
    output logic        m_tlast
);

    logic [lprr_pkg::PTR_W-1:0] buffer_len_reg;
    lprr_pkg::result_t          res;
    lprr_pkg::result_t          out_reg;
    logic                       out_valid_reg;
    logic                       ram_we;
    logic [lprr_pkg::ADDR_W-1:0] ram_addr;
    logic [7:0]                 ram_wdata, ram_rdata;

    // ring length register with clamping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buffer_len_reg <= lprr_pkg::PTR_W'(lprr_pkg::DEPTH);
        end else if (cfg_we) begin
            if (cfg_wdata < lprr_pkg::PTR_W'(lprr_pkg::MIN_LEN)) begin
                buffer_len_reg <= lprr_pkg::PTR_W'(lprr_pkg::MIN_LEN);
            end else if (cfg_wdata > lprr_pkg::PTR_W'(lprr_pkg::DEPTH)) begin
                buffer_len_reg <= lprr_pkg::PTR_W'(lprr_pkg::DEPTH);
            end else begin
                buffer_len_reg <= cfg_wdata;
            end
        end
    end

    lprr_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clr       (cfg_we),
        .blen      (buffer_len_reg),
        .out_busy  (out_valid_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_length (s_tdata[11:0]),
        .in_data   (s_tdata[19:12]),
        .res       (res),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    lprr_ram #(
        .WIDTH (8),
        .DEPTH (lprr_pkg::DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.data_out, out_reg.record_length};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

endmodule
